FILE: rtl/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg: shared constants for the cubic bezier easing core
// widths, defaults and register indexes
// ----------------------------------------------------------------------------
package cbe_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_STEPS_DEF = 100;
    localparam int XW = 17;
    localparam int YW = 19;
    localparam int AW = 2;
    localparam int DW = 32;
    localparam logic [AW-1:0] REG_X1 = 2'd0;
    localparam logic [AW-1:0] REG_Y1 = 2'd1;
    localparam logic [AW-1:0] REG_X2 = 2'd2;
    localparam logic [AW-1:0] REG_Y2 = 2'd3;
    localparam logic [XW-1:0] X1_RST = 17'd16384;
    localparam logic [YW-1:0] Y1_RST = 19'sd0;
    localparam logic [XW-1:0] X2_RST = 17'd49152;
    localparam logic [YW-1:0] Y2_RST = 19'sd65536;
endpackage

FILE: rtl/cbe_mul.sv
// ----------------------------------------------------------------------------
// cbe_mul: shared fixed point multiplier
// signed product, rounded half away from zero, registered result
// ----------------------------------------------------------------------------
module cbe_mul
    import cbe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int W = 32
)
(
    input  logic                clk,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic signed [W-1:0] p_reg
);
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [2*W-1:0] prod;
    logic [2*W-1:0] rnd;
    logic [W-1:0]   mag_r;
    logic           neg;
    logic signed [W-1:0] p_next;

    always_comb
    begin
        ma     = a[W-1] ? (~a + 1'b1) : a;
        mb     = b[W-1] ? (~b + 1'b1) : b;
        neg    = a[W-1] ^ b[W-1];
        prod   = ma * mb;
        rnd    = (prod + ((2*W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        mag_r  = rnd[W-1:0];
        p_next = neg ? -$signed(mag_r) : $signed(mag_r);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end
endmodule

FILE: rtl/cbe_div.sv
// ----------------------------------------------------------------------------
// cbe_div: restoring divider for the newton step
// one quotient bit per cycle, magnitude saturated at eight
// ----------------------------------------------------------------------------
module cbe_div
    import cbe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int W = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output logic                done_reg,
    output logic signed [W-1:0] q_out
);
    localparam int NB = FRAC_BITS + 4;
    localparam int CW = $clog2(W + FRAC_BITS + 1);

    logic [W-1:0]  den_reg;
    logic [W:0]    rem_reg;
    logic [W-1:0]  numm_reg;
    logic [NB-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          neg_reg;
    logic [W:0]    trial;
    logic [W-1:0]  lim;
    logic [W-1:0]  qm;

    assign trial = {rem_reg[W-1:0], numm_reg[W-1]};
    assign lim   = W'(8) << FRAC_BITS;
    assign qm    = (q_reg[NB-1] || (W'(q_reg) >= lim)) ? lim : W'(q_reg);
    assign q_out = neg_reg ? -$signed(qm) : $signed(qm);

    // integer part is covered by shifting the numerator in; bits above
    // three integer bits saturate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W + FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            numm_reg <= num[W-1] ? (~num + 1'b1) : num;
            den_reg  <= den[W-1] ? (~den + 1'b1) : den;
            neg_reg  <= num[W-1] ^ den[W-1];
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            numm_reg <= {numm_reg[W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                q_reg   <= (q_reg[NB-1] ? q_reg : {q_reg[NB-2:0], 1'b1})
                           | {q_reg[NB-1], {(NB-1){1'b0}}};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= q_reg[NB-1] ? q_reg : {q_reg[NB-2:0], 1'b0};
            end
        end
    end
endmodule

FILE: rtl/cubic_bezier_easing_core.sv
// ----------------------------------------------------------------------------
// cubic_bezier_easing_core: css style cubic bezier easing
// newton solve of x(t) = progress, then y(t), on one shared multiplier
// ----------------------------------------------------------------------------
// each newton step: five products on the shared multiplier, a divider run and
// one update; the result strobe follows the y(t) products on convergence, or
// comes straight after the last update when the steps run out
// throughput: one item at a time, busy high until the result strobe
// the result is shown for one cycle on done; the receiver cannot stall
// reset: control registers take their default curve, sequencer goes idle
module cubic_bezier_easing_core
    import cbe_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [AW-1:0]        cfg_index,
    input  logic [DW-1:0]        cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [XW-1:0]        progress,
    output logic                 done,
    output logic signed [YW-1:0] eased_value,
    output logic                 failed
);
    // port widths fix the number of fraction bits
    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam int W  = 32;
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_M2   = 4'd2;
    localparam logic [3:0] S_M3   = 4'd3;
    localparam logic [3:0] S_D1   = 4'd4;
    localparam logic [3:0] S_D2   = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_Y1   = 4'd8;
    localparam logic [3:0] S_Y2   = 4'd9;
    localparam logic [3:0] S_Y3   = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [XW-1:0] x1_reg, x2_reg;
    logic [YW-1:0] y1_reg, y2_reg;
    logic [3:0]    st_reg;
    logic          ph_reg;
    logic [SW-1:0] step_reg;
    logic signed [W-1:0] t_reg, acc_reg, tgt_reg, f_reg;
    logic signed [W-1:0] ma, mb, mp, d_sum;
    logic signed [W-1:0] ax, bx, cx, ay, by, cy;
    logic signed [W-1:0] px1, px2, py1, py2;
    logic signed [W-1:0] q, tn, tc;
    logic          dgo, ddone;
    logic          done_reg, fail_reg;
    logic signed [YW-1:0] y_reg;

    assign cfg_ready   = 1'b1;
    assign busy        = (st_reg != S_IDLE);
    assign done        = done_reg;
    assign failed      = fail_reg;
    assign eased_value = y_reg;

    always_comb
    begin
        px1 = (x1_reg > XW'(ONE)) ? ONE : W'(x1_reg);
        px2 = (x2_reg > XW'(ONE)) ? ONE : W'(x2_reg);
        py1 = W'(signed'(y1_reg));
        py2 = W'(signed'(y2_reg));
        ax  = ONE + 3 * px1 - 3 * px2;
        bx  = 3 * px2 - 6 * px1;
        cx  = 3 * px1;
        ay  = ONE + 3 * py1 - 3 * py2;
        by  = 3 * py2 - 6 * py1;
        cy  = 3 * py1;
    end

    // operand select for the shared multiplier
    always_comb
    begin
        ma = acc_reg;
        mb = t_reg;
        case (st_reg)
            S_M1:    ma = ax;
            S_D1:    ma = 3 * ax;
            S_Y1:    ma = ay;
            default: ma = acc_reg;
        endcase
    end

    cbe_mul #(.FRAC_BITS(FRAC_BITS), .W(W)) u_mul
    (
        .clk   (clk),
        .a     (ma),
        .b     (mb),
        .p_reg (mp)
    );

    // derivative straight from the last product, so the divider sees it
    // at the same edge that starts it
    assign d_sum = mp + cx;

    cbe_div #(.FRAC_BITS(FRAC_BITS), .W(W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (dgo),
        .num      (f_reg),
        .den      (d_sum),
        .done_reg (ddone),
        .q_out    (q)
    );

    assign dgo = (st_reg == S_D2) && ph_reg && (d_sum != '0);

    always_comb
    begin
        tn = t_reg - q;
        if (tn > 4 * ONE)
            tc = 4 * ONE;
        else if (tn < -4 * ONE)
            tc = -4 * ONE;
        else
            tc = tn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= X1_RST;
            y1_reg <= Y1_RST;
            x2_reg <= X2_RST;
            y2_reg <= Y2_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_X1:  x1_reg <= cfg_data[XW-1:0];
                REG_Y1:  y1_reg <= cfg_data[YW-1:0];
                REG_X2:  x2_reg <= cfg_data[XW-1:0];
                REG_Y2:  y2_reg <= cfg_data[YW-1:0];
                default: ;
            endcase
        end
    end

    // each product state: phase 0 issues, phase 1 takes the registered product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            ph_reg   <= 1'b0;
            done_reg <= 1'b0;
            fail_reg <= 1'b0;
            step_reg <= '0;
            tgt_reg  <= '0;
            t_reg    <= '0;
            acc_reg  <= '0;
            f_reg    <= '0;
            y_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            ph_reg   <= ~ph_reg;
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        tgt_reg  <= (progress > XW'(ONE)) ? ONE : W'(progress);
                        t_reg    <= ONE >>> 1;
                        step_reg <= '0;
                        st_reg   <= S_M1;
                        ph_reg   <= 1'b0;
                    end
                end
                // x(t) in horner form: a*t, then +b times t, then +c times t
                S_M1:
                begin
                    if (ph_reg)
                    begin
                        acc_reg <= mp + bx;
                        st_reg  <= S_M2;
                        ph_reg  <= 1'b0;
                    end
                end
                S_M2:
                begin
                    if (ph_reg)
                    begin
                        acc_reg <= mp + cx;
                        st_reg  <= S_M3;
                        ph_reg  <= 1'b0;
                    end
                end
                S_M3:
                begin
                    if (ph_reg)
                    begin
                        f_reg  <= mp - tgt_reg;
                        st_reg <= S_D1;
                        ph_reg <= 1'b0;
                    end
                end
                // x'(t): 3a*t, then +2b times t, then +c
                S_D1:
                begin
                    if (ph_reg)
                    begin
                        acc_reg <= mp + 2 * bx;
                        st_reg  <= S_D2;
                        ph_reg  <= 1'b0;
                    end
                end
                S_D2:
                begin
                    if (ph_reg)
                    begin
                        // flat derivative: the solve gives up
                        if (d_sum == '0)
                        begin
                            fail_reg <= 1'b1;
                            y_reg    <= '0;
                            st_reg   <= S_OUT;
                        end
                        else
                            st_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (ddone)
                        st_reg <= S_UPD;
                end
                S_UPD:
                begin
                    t_reg    <= tc;
                    step_reg <= step_reg + 1'b1;
                    ph_reg   <= 1'b0;
                    if (q <= 1 && q >= -1)
                        st_reg <= S_Y1;
                    else if (step_reg == SW'(MAX_STEPS - 1))
                    begin
                        fail_reg <= 1'b1;
                        y_reg    <= '0;
                        st_reg   <= S_OUT;
                    end
                    else
                        st_reg <= S_M1;
                end
                // y(t) on the solved parameter
                S_Y1:
                begin
                    if (ph_reg)
                    begin
                        acc_reg <= mp + by;
                        st_reg  <= S_Y2;
                        ph_reg  <= 1'b0;
                    end
                end
                S_Y2:
                begin
                    if (ph_reg)
                    begin
                        acc_reg <= mp + cy;
                        st_reg  <= S_Y3;
                        ph_reg  <= 1'b0;
                    end
                end
                S_Y3:
                begin
                    if (ph_reg)
                    begin
                        fail_reg <= 1'b0;
                        if (mp > W'(262143))
                            y_reg <= YW'(262143);
                        else if (mp < -W'(262144))
                            y_reg <= YW'(-262144);
                        else
                            y_reg <= mp[YW-1:0];
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
